>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the convolution core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/core/rcdc_pkg.sv
// ---------------------------------------------------------------------------
// rcdc_pkg
// Types and constants shared by the 3x3 convolution core.
// ---------------------------------------------------------------------------
package rcdc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int ACC_W      = 20;
    localparam int QUO_W      = 19;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DCNT_W     = 5;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_KROW0   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KROW1   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KROW2   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIVISOR = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_MAC,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic shift;
        logic mac_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic mac_last;
        logic div_last;
        logic out_full;
    } sts_t;

endpackage

>>> rtl/core/rcdc_ram.sv
// ---------------------------------------------------------------------------
// rcdc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rcdc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/rcdc_ctrl.sv
// ---------------------------------------------------------------------------
// rcdc_ctrl
// Sequencer that steps the datapath through read and window shift, then,
// for interior pixels only, accumulation, division and output load.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcdc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rcdc_pkg::sts_t sts,
    output rcdc_pkg::cmd_t cmd
);

    rcdc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcdc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            rcdc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = rcdc_pkg::ST_READ;
                end
            end
            rcdc_pkg::ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = rcdc_pkg::ST_SHIFT;
            end
            rcdc_pkg::ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = sts.interior ? rcdc_pkg::ST_MAC : rcdc_pkg::ST_IDLE;
            end
            rcdc_pkg::ST_MAC: begin
                cmd.mac_step = 1'b1;
                if (sts.mac_last) begin
                    state_next = rcdc_pkg::ST_DINIT;
                end
            end
            rcdc_pkg::ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = rcdc_pkg::ST_DIV;
            end
            rcdc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = rcdc_pkg::ST_OUT;
                end
            end
            rcdc_pkg::ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = rcdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcdc_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLKED(a_accept_to_read, aclk, aresetn,
        (s_tvalid && s_tready) |=> (state_reg == rcdc_pkg::ST_READ),
        "Accepted transfer did not start a line store read")
    `ASSERT_NEVER(a_load_when_full, aclk, aresetn, cmd.load_out && sts.out_full,
        "Output register loaded while still occupied")
    `ASSERT_CLKED(a_mac_to_div, aclk, aresetn,
        (cmd.mac_step && sts.mac_last) |=> cmd.div_init,
        "Division did not follow the last accumulation step")

endmodule

>>> rtl/core/rcdc_datapath.sv
// ---------------------------------------------------------------------------
// rcdc_datapath
// Configuration registers, line stores, 3x3 window, multiply-accumulate
// unit, bit-serial divider and output register.
// ---------------------------------------------------------------------------
module rcdc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rcdc_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [rcdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [rcdc_pkg::PIX_W-1:0]          s_tdata,
    output logic [rcdc_pkg::PIX_W-1:0]          m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tlast,
    input  rcdc_pkg::cmd_t                      cmd,
    output rcdc_pkg::sts_t                      sts
);

    logic [23:0]                   kernel_reg [0:2];
    logic [7:0]                    divisor_reg;
    logic [rcdc_pkg::WIDTH_W-1:0]  width_reg;
    logic [rcdc_pkg::ROW_W-1:0]    height_reg;

    logic [rcdc_pkg::PIX_W-1:0]    px_reg;
    logic [rcdc_pkg::PIX_W-1:0]    win_reg [0:2][0:2];
    logic [rcdc_pkg::COL_W-1:0]    col_reg, col_next;
    logic [rcdc_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                          last_reg;
    logic                          interior;
    logic                          at_last;

    logic [1:0]                    mac_row_reg, mac_col_reg;
    logic signed [rcdc_pkg::ACC_W-1:0] acc_reg [0:2];
    logic [rcdc_pkg::QUO_W-1:0]    num_reg [0:2];
    logic [7:0]                    rem_reg [0:2];
    logic [rcdc_pkg::DCNT_W-1:0]   dcnt_reg;

    logic                          out_valid_reg;
    logic [rcdc_pkg::PIX_W-1:0]    out_data_reg;
    logic                          out_last_reg;

    logic [rcdc_pkg::PIX_W-1:0]    top_rd, mid_rd;
    logic [rcdc_pkg::WIDTH_W-1:0]  w_eff;
    logic [rcdc_pkg::ROW_W-1:0]    h_eff;
    logic [7:0]                    d_eff;
    logic [rcdc_pkg::WIDTH_W-1:0]  col_inc;
    logic [rcdc_pkg::ROW_W:0]      row_inc;
    logic [rcdc_pkg::PIX_W-1:0]    sel_px;
    logic signed [7:0]             coef;
    logic signed [16:0]            prod [0:2];
    logic [8:0]                    rem_sh [0:2];
    logic                          ge [0:2];
    logic [rcdc_pkg::PIX_W-1:0]    result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg[0] <= 24'h000000;
            kernel_reg[1] <= 24'h010000;
            kernel_reg[2] <= 24'h000000;
            divisor_reg   <= 8'd1;
            width_reg     <= rcdc_pkg::WIDTH_W'(1024);
            height_reg    <= rcdc_pkg::ROW_W'(768);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rcdc_pkg::REG_KROW0:   kernel_reg[0] <= cfg_wdata;
                rcdc_pkg::REG_KROW1:   kernel_reg[1] <= cfg_wdata;
                rcdc_pkg::REG_KROW2:   kernel_reg[2] <= cfg_wdata;
                rcdc_pkg::REG_DIVISOR: divisor_reg   <= cfg_wdata[7:0];
                rcdc_pkg::REG_WIDTH:   width_reg     <= cfg_wdata[rcdc_pkg::WIDTH_W-1:0];
                rcdc_pkg::REG_HEIGHT:  height_reg    <= cfg_wdata[rcdc_pkg::ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (width_reg < rcdc_pkg::WIDTH_W'(3)) begin
            w_eff = rcdc_pkg::WIDTH_W'(3);
        end else if (width_reg > rcdc_pkg::WIDTH_W'(rcdc_pkg::MAX_WIDTH)) begin
            w_eff = rcdc_pkg::WIDTH_W'(rcdc_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < rcdc_pkg::ROW_W'(3)) ? rcdc_pkg::ROW_W'(3) : height_reg;
        d_eff = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
    end

    rcdc_ram #(.WIDTH(rcdc_pkg::PIX_W), .DEPTH(rcdc_pkg::MAX_WIDTH)) u_top_ram (
        .aclk    (aclk),
        .wr_en   (cmd.shift),
        .wr_addr (col_reg[rcdc_pkg::ADDR_W-1:0]),
        .wr_data (mid_rd),
        .rd_en   (cmd.rd_en),
        .rd_addr (col_reg[rcdc_pkg::ADDR_W-1:0]),
        .rd_data (top_rd)
    );

    rcdc_ram #(.WIDTH(rcdc_pkg::PIX_W), .DEPTH(rcdc_pkg::MAX_WIDTH)) u_mid_ram (
        .aclk    (aclk),
        .wr_en   (cmd.shift),
        .wr_addr (col_reg[rcdc_pkg::ADDR_W-1:0]),
        .wr_data (px_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (col_reg[rcdc_pkg::ADDR_W-1:0]),
        .rd_data (mid_rd)
    );

    always_comb begin
        interior = (row_reg >= rcdc_pkg::ROW_W'(2)) && (col_reg >= rcdc_pkg::COL_W'(2))
                && (row_reg < h_eff) && ({1'b0, col_reg} < w_eff);
        at_last  = (row_reg == h_eff - rcdc_pkg::ROW_W'(1))
                && ({1'b0, col_reg} == w_eff - rcdc_pkg::WIDTH_W'(1));
        col_inc  = {1'b0, col_reg} + rcdc_pkg::WIDTH_W'(1);
        row_inc  = {1'b0, row_reg} + (rcdc_pkg::ROW_W+1)'(1);
        col_next = col_inc[rcdc_pkg::COL_W-1:0];
        row_next = row_reg;
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = row_inc[rcdc_pkg::ROW_W-1:0];
            if (row_inc >= {1'b0, h_eff}) begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            last_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cmd.shift) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            last_reg <= at_last;
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= px_reg;
        end
    end

    always_comb begin
        sel_px = win_reg[mac_row_reg][mac_col_reg];
        case (mac_col_reg)
            2'd0:    coef = $signed(kernel_reg[mac_row_reg][7:0]);
            2'd1:    coef = $signed(kernel_reg[mac_row_reg][15:8]);
            default: coef = $signed(kernel_reg[mac_row_reg][23:16]);
        endcase
        for (int c = 0; c < 3; c++) begin
            prod[c] = $signed({1'b0, sel_px[8*c +: 8]}) * coef;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_row_reg <= '0;
            mac_col_reg <= '0;
        end else if (cmd.shift) begin
            mac_row_reg <= '0;
            mac_col_reg <= '0;
        end else if (cmd.mac_step) begin
            if (mac_col_reg == 2'd2) begin
                mac_col_reg <= '0;
                mac_row_reg <= mac_row_reg + 2'd1;
            end else begin
                mac_col_reg <= mac_col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            if (cmd.shift) begin
                acc_reg[c] <= '0;
            end else if (cmd.mac_step) begin
                acc_reg[c] <= acc_reg[c] + rcdc_pkg::ACC_W'(prod[c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rem_sh[c] = {rem_reg[c], num_reg[c][rcdc_pkg::QUO_W-1]};
            ge[c]     = rem_sh[c] >= {1'b0, d_eff};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + rcdc_pkg::DCNT_W'(1);
        end
        for (int c = 0; c < 3; c++) begin
            if (cmd.div_init) begin
                num_reg[c] <= acc_reg[c][rcdc_pkg::ACC_W-1] ? '0
                            : acc_reg[c][rcdc_pkg::QUO_W-1:0];
                rem_reg[c] <= '0;
            end else if (cmd.div_step) begin
                num_reg[c] <= {num_reg[c][rcdc_pkg::QUO_W-2:0], ge[c]};
                rem_reg[c] <= ge[c] ? 8'(rem_sh[c] - {1'b0, d_eff}) : rem_sh[c][7:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            result[8*c +: 8] = (num_reg[c] > rcdc_pkg::QUO_W'(255)) ? 8'd255
                             : num_reg[c][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= result;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        sts.interior = interior;
        sts.mac_last = (mac_row_reg == 2'd2) && (mac_col_reg == 2'd2);
        sts.div_last = (dcnt_reg == rcdc_pkg::DCNT_W'(rcdc_pkg::DIV_STEPS - 1));
        sts.out_full = out_valid_reg && !m_tready;
    end

endmodule

>>> rtl/core/rgb_conv3x3_div_clamp_unit.sv
// ---------------------------------------------------------------------------
// rgb_conv3x3_div_clamp_unit
// 3x3 RGB convolution with signed kernel, integer divisor and clamp.
//
//   Channel  Direction  Ports                 Contents
//   s_       in         tvalid/tready/tdata   red, green, blue
//   m_       out        tvalid/tready/tdata   red, green, blue; tlast = frame end
//   cfg_     in         wr_en/index/wdata     kernel rows, divisor, width, height
//
// A border pixel is only read and shifted; an interior pixel also takes
// nine passes of the shared multiply-accumulate unit and 19 divider steps.
// Reset is synchronous and active low; line store contents are not cleared.
// A stalled output holds the next result in the sequencer until the output
// register is free; the input is taken again once the result is loaded.
// ---------------------------------------------------------------------------
module rgb_conv3x3_div_clamp_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rcdc_pkg::PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rcdc_pkg::PIX_W-1:0]       m_tdata,   // red_out, green_out, blue_out
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [rcdc_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [rcdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    rcdc_pkg::cmd_t cmd;
    rcdc_pkg::sts_t sts;

    rcdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcdc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for rgb_conv3x3_div_clamp_unit
// Streams whole RGB frames through the filter under a range of kernels,
// divisors and image sizes. A scoreboard keeps its own line stores and
// window, works out each interior pixel and compares it with the output.
// ---------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 40;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       frame_end;
    } filtered_px_t;

    class conv_scoreboard;
        bit [23:0]    kernel[3];
        int           divisor;
        int           width_reg;
        int           height_reg;
        bit [23:0]    lines[2*rcdc_pkg::MAX_WIDTH];
        bit [23:0]    win[3][3];
        int           col;
        int           row;
        filtered_px_t pending[$];
        int           errors;
        int           results_seen;
        int           pixels_seen;

        function void reset_state();
            kernel[0]  = 24'h000000;
            kernel[1]  = 24'h010000;
            kernel[2]  = 24'h000000;
            divisor    = 1;
            width_reg  = 1024;
            height_reg = 768;
            foreach (lines[i]) lines[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col = 0;
            row = 0;
        endfunction

        function void set_reg(logic [rcdc_pkg::CFG_ADDR_W-1:0] idx, bit [23:0] val);
            case (idx)
                rcdc_pkg::REG_KROW0:   kernel[0] = val;
                rcdc_pkg::REG_KROW1:   kernel[1] = val;
                rcdc_pkg::REG_KROW2:   kernel[2] = val;
                rcdc_pkg::REG_DIVISOR: divisor = val[7:0];
                rcdc_pkg::REG_WIDTH:   width_reg = val[10:0];
                rcdc_pkg::REG_HEIGHT:  height_reg = val[11:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] filter_chan(int ch);
            int acc;
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc += int'(win[i][j][8*ch +: 8]) * int'($signed(kernel[i][8*j +: 8]));
                end
            end
            if (divisor > 1) acc = acc / divisor;
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            return acc[7:0];
        endfunction

        function void note_pixel(bit [23:0] px);
            int w;
            int h;
            bit [23:0] top;
            bit [23:0] mid;
            filtered_px_t fp;
            w = (width_reg < 3) ? 3 : ((width_reg > rcdc_pkg::MAX_WIDTH) ?
                rcdc_pkg::MAX_WIDTH : width_reg);
            h = (height_reg < 3) ? 3 : height_reg;
            top = lines[rcdc_pkg::MAX_WIDTH + col];
            mid = lines[col];
            lines[rcdc_pkg::MAX_WIDTH + col] = mid;
            lines[col] = px;
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = px;
            if (row >= 2 && col >= 2 && row < h && col < w) begin
                fp.red       = filter_chan(0);
                fp.green     = filter_chan(1);
                fp.blue      = filter_chan(2);
                fp.frame_end = (row == h - 1 && col == w - 1);
                pending.push_back(fp);
            end
            pixels_seen++;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
            errors++;
        endtask

        task check_result(bit [23:0] data, bit last);
            filtered_px_t fp;
            if (pending.size() == 0) begin
                report("unexpected result data", int'(data), 0);
            end else begin
                fp = pending.pop_front();
                if (data[7:0] != fp.red) report("red", data[7:0], fp.red);
                if (data[15:8] != fp.green) report("green", data[15:8], fp.green);
                if (data[23:16] != fp.blue) report("blue", data[23:16], fp.blue);
                if (last != fp.frame_end) report("frame end", last, fp.frame_end);
            end
            results_seen++;
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rcdc_pkg::PIX_W-1:0]      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rcdc_pkg::PIX_W-1:0]      m_tdata;
    logic                            m_tlast;
    logic                            cfg_wr_en;
    logic [rcdc_pkg::CFG_ADDR_W-1:0] cfg_index;
    logic [rcdc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    conv_scoreboard sb;
    bit             no_gaps;
    int             frames_run;
    int             idle_cycles;

    rgb_conv3x3_div_clamp_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        sb = new();
        sb.reset_state();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        no_gaps   = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("testbench failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    initial begin : result_sink
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    task send_pixel(bit [23:0] px);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_reg(logic [rcdc_pkg::CFG_ADDR_W-1:0] idx, bit [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task configure(bit [23:0] k0, bit [23:0] k1, bit [23:0] k2,
                   bit [7:0] dv, bit [10:0] w, bit [11:0] h);
        write_reg(rcdc_pkg::REG_KROW0, k0);
        write_reg(rcdc_pkg::REG_KROW1, k1);
        write_reg(rcdc_pkg::REG_KROW2, k2);
        write_reg(rcdc_pkg::REG_DIVISOR, 24'(dv));
        write_reg(rcdc_pkg::REG_WIDTH, 24'(w));
        write_reg(rcdc_pkg::REG_HEIGHT, 24'(h));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function bit [7:0] pick_chan();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function bit [23:0] pick_kernel_row();
        case ($urandom_range(0, 5))
            0: return 24'h808080;
            1: return 24'h7f7f7f;
            2: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                       8'($urandom_range(0, 3))};
            default: return 24'($urandom_range(0, 24'hffffff));
        endcase
    endfunction

    task run_frame(int npix, bit pause_midway);
        for (int n = 0; n < npix; n++) begin
            if (pause_midway && n == npix / 2) wait_drained();
            send_pixel({pick_chan(), pick_chan(), pick_chan()});
        end
        frames_run++;
    endtask

    initial begin : stimulus
        int w;
        int h;
        bit [10:0] wr;
        bit [11:0] hr;
        bit [7:0] dv;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity kernel over a 5x5 frame of extreme and mixed pixels.
        configure(24'h000000, 24'h000100, 24'h000000, 8'd1, 11'd5, 12'd5);
        for (int n = 0; n < 25; n++) begin
            case (n % 5)
                0: send_pixel(24'h000000);
                1: send_pixel(24'hffffff);
                2: send_pixel(24'hff00ff);
                3: send_pixel(24'h00ff00);
                default: send_pixel(24'($urandom_range(0, 24'hffffff)));
            endcase
        end
        frames_run++;
        wait_drained();

        // Most negative and most positive kernels, divisor zero and largest.
        configure(24'h808080, 24'h808080, 24'h808080, 8'd0, 11'd0, 12'd0);
        run_frame(9, 1'b0);
        wait_drained();
        configure(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 8'd255, 11'd2, 12'd2);
        run_frame(9, 1'b0);
        wait_drained();
        configure(24'h81ff01, 24'h7f0080, 24'hfe02c0, 8'd1, 11'd1, 12'd1);
        run_frame(9, 1'b0);
        wait_drained();

        while (sb.pixels_seen < 950) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: dv = 8'd1;
                1: dv = 8'd0;
                2: dv = 8'd255;
                default: dv = 8'($urandom_range(2, 254));
            endcase
            wr = 11'($urandom_range(0, 12));
            hr = 12'($urandom_range(0, 8));
            configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), dv, wr, hr);
            w = (wr < 3) ? 3 : wr;
            h = (hr < 3) ? 3 : hr;
            repeat ($urandom_range(1, 2)) run_frame(w * h, frames_run == 10);
            wait_drained();
        end
        no_gaps = 1'b0;

        // A narrow, tall frame.
        configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 8'd3,
                  11'd3, 12'd64);
        run_frame(3 * 64, 1'b0);
        wait_drained();

        $display("covered %0d frames, %0d pixels in and %0d filtered pixels out",
                 frames_run, sb.pixels_seen, sb.results_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("testbench failed");
        end
        $finish;
    end
endmodule
